FILE: rtl/core/mselg_pkg.sv
// ----------------------------------------------------------------------------
// mselg_pkg
// Shared widths and controller/datapath handshake types for the mse loss block
// ----------------------------------------------------------------------------
package mselg_pkg;

   localparam int DATA_WIDTH = 16;              // significant bits of each element
   localparam int FIELD_W    = 16;              // width of prediction and target
   localparam int GRAD_W     = 32;              // gradient width
   localparam int ERR_W      = 44;              // sample error and batch mean width
   localparam int BSUM_W     = 53;              // batch sum width
   localparam int CNT_W      = 9;               // sample count width
   localparam int DIFF_W     = DATA_WIDTH + 1;  // prediction minus target
   localparam int SQ_W       = 2 * DATA_WIDTH;  // square of the difference
   localparam int DIV_STEPS  = BSUM_W;          // one quotient bit per cycle
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   typedef struct packed {
      logic load;
      logic mul;
      logic acc;
      logic bat;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic end_batch;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/core/mselg_req_if.sv
// ----------------------------------------------------------------------------
// mselg_req_if
// Request channel: one prediction/target element pair with its markers
// ----------------------------------------------------------------------------
interface mselg_req_if;
   import mselg_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] prediction;
   logic signed [FIELD_W-1:0] target;
   logic signed [GRAD_W-1:0]  prev_gradient;
   logic                      last_in_sample;
   logic                      last_in_batch;

   modport source (
      output valid, prediction, target, prev_gradient, last_in_sample, last_in_batch,
      input  ready
   );

   modport sink (
      input  valid, prediction, target, prev_gradient, last_in_sample, last_in_batch,
      output ready
   );

endinterface

FILE: rtl/core/mselg_rsp_if.sv
// ----------------------------------------------------------------------------
// mselg_rsp_if
// Response channel: gradient, sample error and batch mean for one request
// ----------------------------------------------------------------------------
interface mselg_rsp_if;
   import mselg_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [GRAD_W-1:0] gradient;
   logic [ERR_W-1:0]         sample_error;
   logic                     sample_done;
   logic [ERR_W-1:0]         batch_mean;
   logic                     batch_done;

   modport source (
      output valid, gradient, sample_error, sample_done, batch_mean, batch_done,
      input  ready
   );

   modport sink (
      input  valid, gradient, sample_error, sample_done, batch_mean, batch_done,
      output ready
   );

endinterface

FILE: rtl/core/mselg_ctrl.sv
// ----------------------------------------------------------------------------
// mselg_ctrl
// Sequencer: steps each request through square, sums, divide at a batch end and output load
// ----------------------------------------------------------------------------
module mselg_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mselg_pkg::status_type status,
   output mselg_pkg::cmd_type    cmd
);
   import mselg_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_ACC  = 3'd2;
   localparam logic [2:0] ST_BAT  = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]           state_ff;
   logic [2:0]           state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff;
   logic [DIV_CNT_W-1:0] div_cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.acc  = 1'b1;
            state_in = ST_BAT;
         end
         ST_BAT: begin
            cmd.bat    = 1'b1;
            div_cnt_in = '0;
            state_in   = status.end_batch ? ST_DIV : ST_OUT;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_OUT;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         ST_OUT: begin
            // wait for the response register to drain
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

endmodule

FILE: rtl/core/mselg_dpath.sv
// ----------------------------------------------------------------------------
// mselg_dpath
// Datapath: difference, square, saturating sums, serial divider, response reg
// ----------------------------------------------------------------------------
module mselg_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  mselg_pkg::cmd_type               cmd,
   output mselg_pkg::status_type            status,
   input  logic                             csr_wr_en,
   input  logic                             csr_wr_data,
   input  logic signed [mselg_pkg::FIELD_W-1:0] req_prediction,
   input  logic signed [mselg_pkg::FIELD_W-1:0] req_target,
   input  logic signed [mselg_pkg::GRAD_W-1:0]  req_prev_gradient,
   input  logic                             req_last_in_sample,
   input  logic                             req_last_in_batch,
   input  logic                             rsp_ready,
   output logic                             rsp_valid,
   output logic signed [mselg_pkg::GRAD_W-1:0]  rsp_gradient,
   output logic [mselg_pkg::ERR_W-1:0]      rsp_sample_error,
   output logic                             rsp_sample_done,
   output logic [mselg_pkg::ERR_W-1:0]      rsp_batch_mean,
   output logic                             rsp_batch_done
);
   import mselg_pkg::*;

   localparam logic [ERR_W-1:0]  ERR_MAX  = '1;
   localparam logic [BSUM_W-1:0] BSUM_MAX = '1;
   localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
   localparam logic signed [GRAD_W-1:0] G_MAX = {1'b0, {(GRAD_W-1){1'b1}}};
   localparam logic signed [GRAD_W-1:0] G_MIN = {1'b1, {(GRAD_W-1){1'b0}}};

   // configuration
   logic accum_ff;

   // captured request
   logic signed [DIFF_W-1:0] diff_ff;
   logic signed [GRAD_W-1:0] prev_ff;
   logic                     end_s_ff;
   logic                     end_b_ff;

   // square stage
   logic [SQ_W-1:0]          sq_ff;
   logic signed [GRAD_W-1:0] grad_ff;

   // running sums
   logic [ERR_W-1:0]  sample_sum_ff;
   logic [BSUM_W-1:0] batch_sum_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ERR_W-1:0]  err_ff;

   // divider
   logic [BSUM_W-1:0] div_q_ff;
   logic [CNT_W-1:0]  div_r_ff;
   logic [CNT_W-1:0]  div_d_ff;

   // response register
   logic                     rsp_valid_ff;
   logic signed [GRAD_W-1:0] rsp_grad_ff;
   logic [ERR_W-1:0]         rsp_err_ff;
   logic                     rsp_sdone_ff;
   logic [ERR_W-1:0]         rsp_mean_ff;
   logic                     rsp_bdone_ff;

   logic signed [DIFF_W-1:0]   pred_ext;
   logic signed [DIFF_W-1:0]   tgt_ext;
   logic signed [2*DIFF_W-1:0] prod;
   logic signed [GRAD_W:0]     gsum;
   logic signed [GRAD_W-1:0]   grad_sat;
   logic [ERR_W:0]             ssum;
   logic [ERR_W-1:0]           ssum_sat;
   logic [BSUM_W:0]            bsum;
   logic [BSUM_W-1:0]          bsum_sat;
   logic [CNT_W-1:0]           count_inc;
   logic [CNT_W:0]             rem_sh;
   logic                       quot_bit;
   logic [ERR_W-1:0]           mean_sat;

   // low DATA_WIDTH bits of each element, sign extended
   assign pred_ext = DIFF_W'(signed'(req_prediction[DATA_WIDTH-1:0]));
   assign tgt_ext  = DIFF_W'(signed'(req_target[DATA_WIDTH-1:0]));

   assign prod = diff_ff * diff_ff;
   assign gsum = (GRAD_W+1)'(prev_ff) + (GRAD_W+1)'(diff_ff);

   always_comb begin
      if (gsum[GRAD_W] != gsum[GRAD_W-1]) begin
         grad_sat = gsum[GRAD_W] ? G_MIN : G_MAX;
      end else begin
         grad_sat = gsum[GRAD_W-1:0];
      end
   end

   assign ssum     = {1'b0, sample_sum_ff} + (ERR_W+1)'(sq_ff);
   assign ssum_sat = ssum[ERR_W] ? ERR_MAX : ssum[ERR_W-1:0];

   assign bsum      = {1'b0, batch_sum_ff} + (BSUM_W+1)'(err_ff);
   assign bsum_sat  = bsum[BSUM_W] ? BSUM_MAX : bsum[BSUM_W-1:0];
   assign count_inc = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;

   // restoring divider, one quotient bit per step
   assign rem_sh   = {div_r_ff, div_q_ff[BSUM_W-1]};
   assign quot_bit = (rem_sh >= {1'b0, div_d_ff});

   assign mean_sat = (div_q_ff[BSUM_W-1:ERR_W] != '0) ? ERR_MAX : div_q_ff[ERR_W-1:0];

   assign status.end_batch = end_b_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   // control and accumulator state
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff      <= 1'b0;
         sample_sum_ff <= '0;
         batch_sum_ff  <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            accum_ff <= csr_wr_data;
         end
         if (cmd.acc) begin
            sample_sum_ff <= end_s_ff ? '0 : ssum_sat;
         end
         if (cmd.bat && end_s_ff) begin
            batch_sum_ff <= end_b_ff ? '0 : bsum_sat;
            count_ff     <= end_b_ff ? '0 : count_inc;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         diff_ff  <= pred_ext - tgt_ext;
         prev_ff  <= req_prev_gradient;
         end_s_ff <= req_last_in_sample || req_last_in_batch;
         end_b_ff <= req_last_in_batch;
      end
      if (cmd.mul) begin
         sq_ff   <= prod[SQ_W-1:0];
         grad_ff <= accum_ff ? grad_sat : GRAD_W'(diff_ff);
      end
      if (cmd.acc) begin
         err_ff <= end_s_ff ? ssum_sat : '0;
      end
      if (cmd.bat) begin
         div_q_ff <= bsum_sat;
         div_r_ff <= '0;
         div_d_ff <= count_inc;
      end
      if (cmd.div_step) begin
         div_r_ff <= quot_bit ? CNT_W'(rem_sh - {1'b0, div_d_ff}) : rem_sh[CNT_W-1:0];
         div_q_ff <= {div_q_ff[BSUM_W-2:0], quot_bit};
      end
      if (cmd.out_load) begin
         rsp_grad_ff  <= grad_ff;
         rsp_err_ff   <= err_ff;
         rsp_sdone_ff <= end_s_ff;
         rsp_mean_ff  <= end_b_ff ? mean_sat : '0;
         rsp_bdone_ff <= end_b_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gradient     = rsp_grad_ff;
   assign rsp_sample_error = rsp_err_ff;
   assign rsp_sample_done  = rsp_sdone_ff;
   assign rsp_batch_mean   = rsp_mean_ff;
   assign rsp_batch_done   = rsp_bdone_ff;

endmodule

FILE: rtl/core/mse_loss_and_gradient.sv
// ----------------------------------------------------------------------------
// mse_loss_and_gradient
// Streaming mean squared error loss with per-element gradient
// ----------------------------------------------------------------------------
//  channel   dir   carries
//  req_bus   in    prediction, target, prev_gradient, last_in_sample, last_in_batch
//  rsp_bus   out   gradient, sample_error, sample_done, batch_mean, batch_done
//  csr_*     in    accumulate_gradient write
//
//  a request steps through capture, square and gradient, sample sum, batch sum
//  and response load before the next acceptance
//  a request ending a batch also runs the one-bit-per-cycle divider
//  the response register lets a new request in while the last response waits
//  a full response register stalls the sequencer in its output step
//  synchronous reset clears the sums, sample count, register and sequencer
// ----------------------------------------------------------------------------
module mse_loss_and_gradient (
   input  logic         clock,
   input  logic         reset,
   mselg_req_if.sink    req_bus,
   mselg_rsp_if.source  rsp_bus,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);
   import mselg_pkg::*;

   cmd_type    cmd;
   status_type status;

   mselg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   mselg_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_prediction     (req_bus.prediction),
      .req_target         (req_bus.target),
      .req_prev_gradient  (req_bus.prev_gradient),
      .req_last_in_sample (req_bus.last_in_sample),
      .req_last_in_batch  (req_bus.last_in_batch),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_gradient       (rsp_bus.gradient),
      .rsp_sample_error   (rsp_bus.sample_error),
      .rsp_sample_done    (rsp_bus.sample_done),
      .rsp_batch_mean     (rsp_bus.batch_mean),
      .rsp_batch_done     (rsp_bus.batch_done)
   );

   // an accepted request moves straight into the square step
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> cmd.mul)
      else $error("accepted request did not reach the square step");

   // the sequencer issues at most one datapath command per cycle
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul, cmd.acc, cmd.bat, cmd.div_step, cmd.out_load}))
      else $error("more than one datapath command at once");

   // a loaded response is presented on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_bus.valid)
      else $error("response load did not raise valid");

   // a batch end always closes its sample too
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.batch_done) |-> rsp_bus.sample_done)
      else $error("batch end without sample end");

   // no sample error reported outside a sample end
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.sample_done) |-> (rsp_bus.sample_error == '0))
      else $error("sample error set without sample end");

endmodule
